// ----- rtl/core/css_pkg.sv -----
// shared types and constants for the coil shuttle sequencer
`default_nettype none

package css_pkg;

    localparam int unsigned TICKS_W      = 16;
    localparam int unsigned SENSORS_W    = 4;
    localparam logic [TICKS_W-1:0] BUDGET_RESET = 16'd500;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_ENDS     = 3'd1,
        ST_IN_SET   = 3'd2,
        ST_IN_CLEAR = 3'd3,
        ST_FAR_IN   = 3'd4,
        ST_FAR_END  = 3'd5,
        ST_ONLY_FAR = 3'd6
    } stage_t;

    typedef enum logic [1:0] {
        COIL_BRAKE = 2'd0,
        COIL_IN    = 2'd1,
        COIL_OUT   = 2'd2,
        COIL_OPEN  = 2'd3
    } coil_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } opcode_t;

    typedef struct packed {
        stage_t              stage;
        logic                going_right;
        logic [TICKS_W-1:0]  ticks_left;
        coil_t               coil;
    } css_state_t;

    typedef struct packed {
        logic  reached_far;
        logic  done_res;
        logic  busy_res;
        coil_t coil_mode;
    } css_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/css_cascade.sv -----
// wait cascade for one sensor word: next sequencer state and result
`default_nettype none

module css_cascade
    import css_pkg::*;
(
    input  css_state_t              cur,
    input  opcode_t                 opcode,
    input  logic                    direction,
    input  logic [SENSORS_W-1:0]    sensors,
    input  logic [TICKS_W-1:0]      timeout_ticks,
    output css_state_t              nxt,
    output css_result_t             res
);

    localparam int unsigned MAX_CHECKS = 5;

    always_comb begin
        stage_t              st;
        coil_t               drv;
        logic                gr;
        logic [TICKS_W-1:0]  tl;
        logic                stop;
        logic                dec;
        logic                met;
        logic                done;
        logic                far_ok;
        logic                s_near_end;
        logic                s_far_end;
        logic                s_near_in;
        logic                s_far_in;
        logic                budget_gone;

        st     = cur.stage;
        drv    = cur.coil;
        gr     = cur.going_right;
        tl     = cur.ticks_left;
        stop   = 1'b0;
        dec    = 1'b0;
        met    = 1'b0;
        done   = 1'b0;
        far_ok = 1'b0;

        if (st == ST_IDLE && opcode == OP_START) begin
            gr  = direction;
            tl  = timeout_ticks;
            drv = COIL_OUT;
            st  = ST_ENDS;
        end

        s_near_end  = gr ? sensors[3] : sensors[0];
        s_far_end   = gr ? sensors[0] : sensors[3];
        s_near_in   = gr ? sensors[2] : sensors[1];
        s_far_in    = gr ? sensors[1] : sensors[2];
        budget_gone = (tl == '0);

        for (int i = 0; i < MAX_CHECKS; i++) begin
            if (!stop && st != ST_IDLE) begin
                unique case (st)
                    ST_ENDS:                 met = s_near_end | s_far_end;
                    ST_IN_SET:               met = s_near_in;
                    ST_IN_CLEAR:             met = !s_near_in;
                    ST_FAR_IN:               met = s_far_in;
                    ST_FAR_END, ST_ONLY_FAR: met = s_far_end;
                    default: begin
                        met  = 1'b1;
                        st   = ST_IDLE;
                        stop = 1'b1;
                    end
                endcase
                if (!stop) begin
                    if (!met && !budget_gone) begin
                        dec  = 1'b1;
                        stop = 1'b1;
                    end else begin
                        unique case (st)
                            ST_ENDS: begin
                                if (s_near_end) begin
                                    drv = COIL_IN;
                                    st  = ST_IN_SET;
                                end else begin
                                    st  = ST_ONLY_FAR;
                                end
                            end
                            ST_IN_SET:   st = ST_IN_CLEAR;
                            ST_IN_CLEAR: begin
                                drv = COIL_OPEN;
                                st  = ST_FAR_IN;
                            end
                            ST_FAR_IN: begin
                                drv = COIL_OUT;
                                st  = ST_FAR_END;
                            end
                            ST_FAR_END: begin
                                drv    = COIL_BRAKE;
                                st     = ST_IDLE;
                                done   = 1'b1;
                                far_ok = 1'b1;
                            end
                            default: begin
                                drv    = COIL_BRAKE;
                                st     = ST_IDLE;
                                done   = 1'b1;
                                far_ok = 1'b0;
                            end
                        endcase
                    end
                end
            end
        end

        nxt.stage       = st;
        nxt.going_right = gr;
        nxt.ticks_left  = dec ? tl - 1'b1 : tl;
        nxt.coil        = drv;

        res.coil_mode   = drv;
        res.busy_res    = (st != ST_IDLE);
        res.done_res    = done;
        res.reached_far = far_ok;
    end

endmodule

`default_nettype wire

// ----- rtl/core/coil_shuttle_sequencer_unit.sv -----
// top level of the coil shuttle sequencer: state, budget register and output word
//
//  channel   dir  tdata                                  tuser
//  s_        in   [0] direction [4:1] sensors            [0] opcode
//  m_        out  [1:0] coil_mode [2] busy_res           -
//                 [3] done_res [4] reached_far
//  cfg       in   cfg_wdata = timeout_ticks              -
//
// one word per cycle while the output word is taken; the result appears in the cycle after acceptance
// the whole wait cascade for a word resolves combinationally before the result register
// a stalled output holds its word; s_tready falls only while it is full and not taken
// reset idles the sequencer, brakes the coil and loads a budget of 500 ticks
`default_nettype none

module coil_shuttle_sequencer_unit
    import css_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // direction, sensors[3:0], zero fill
    input  logic [0:0]           s_tuser,   // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // coil_mode[1:0], busy_res, done_res, reached_far
    input  logic                 cfg_we,
    input  logic [TICKS_W-1:0]   cfg_wdata
);

    css_state_t          state_reg;
    css_state_t          state_next;
    css_result_t         res_reg;
    css_result_t         res_next;
    logic                m_tvalid_reg;
    logic [TICKS_W-1:0]  timeout_reg;
    logic                accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    css_cascade u_cascade (
        .cur           (state_reg),
        .opcode        (opcode_t'(s_tuser[0])),
        .direction     (s_tdata[0]),
        .sensors       (s_tdata[SENSORS_W:1]),
        .timeout_ticks (timeout_reg),
        .nxt           (state_next),
        .res           (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= BUDGET_RESET;
        end else if (cfg_we) begin
            timeout_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.stage       <= ST_IDLE;
            state_reg.going_right <= 1'b0;
            state_reg.ticks_left  <= '0;
            state_reg.coil        <= COIL_BRAKE;
            m_tvalid_reg          <= 1'b0;
        end else begin
            if (accept) begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, res_reg};

    a_idle_brakes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.stage == ST_IDLE |-> state_reg.coil == COIL_BRAKE)
        else $error("idle sequencer with coil not braked");

    a_far_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.reached_far |-> res_reg.done_res && !res_reg.busy_res)
        else $error("reached_far without a finished operation");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted word produced no result");

    a_budget_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(state_reg))
        else $error("sequencer state moved without an accepted word");

    a_budget_no_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && state_reg.stage != ST_IDLE
        |=> state_reg.ticks_left <= $past(state_reg.ticks_left))
        else $error("tick budget grew during an operation");

endmodule

`default_nettype wire

// ----- dv/tb_coil_shuttle_sequencer_unit.sv -----
// self-checking testbench for the coil shuttle sequencer top level
module tb_coil_shuttle_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import css_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned PHASE_WORDS = 160;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;   // direction, sensors[3:0], zero fill
    logic [0:0]          s_tuser;   // opcode
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;   // coil_mode[1:0], busy_res, done_res, reached_far
    logic                cfg_we;
    logic [TICKS_W-1:0]  cfg_wdata;

    stage_t              pr_stage;
    coil_t               pr_coil;
    logic                pr_right;
    logic [TICKS_W-1:0]  pr_ticks;
    logic [TICKS_W-1:0]  pr_budget;

    css_result_t         expected_words[$];
    css_result_t         got_word;
    css_result_t         want_word;
    int unsigned         errors = 0;
    int unsigned         quiet_cycles = 0;
    bit                  gaps_on = 1'b1;
    bit                  stall_on = 1'b1;

    coil_shuttle_sequencer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic css_result_t shuttle_predict(opcode_t op, logic dir, logic [3:0] sens);
        css_result_t r;
        logic        met;
        logic        halt;
        logic        done;
        logic        far_ok;
        int unsigned ne, fe, ni, fi;
        done   = 1'b0;
        far_ok = 1'b0;
        halt   = 1'b0;
        if (pr_stage == ST_IDLE && op == OP_START) begin
            pr_right = dir;
            pr_ticks = pr_budget;
            pr_coil  = COIL_OUT;
            pr_stage = ST_ENDS;
        end
        ne = pr_right ? 3 : 0;
        fe = pr_right ? 0 : 3;
        ni = pr_right ? 2 : 1;
        fi = pr_right ? 1 : 2;
        while (pr_stage != ST_IDLE && !halt) begin
            case (pr_stage)
                ST_ENDS:     met = sens[ne] | sens[fe];
                ST_IN_SET:   met = sens[ni];
                ST_IN_CLEAR: met = !sens[ni];
                ST_FAR_IN:   met = sens[fi];
                default:     met = sens[fe];
            endcase
            if (!met && pr_ticks != '0) begin
                pr_ticks = pr_ticks - 1'b1;
                halt     = 1'b1;
            end else begin
                case (pr_stage)
                    ST_ENDS: begin
                        if (sens[ne]) begin
                            pr_coil  = COIL_IN;
                            pr_stage = ST_IN_SET;
                        end else begin
                            pr_stage = ST_ONLY_FAR;
                        end
                    end
                    ST_IN_SET: pr_stage = ST_IN_CLEAR;
                    ST_IN_CLEAR: begin
                        pr_coil  = COIL_OPEN;
                        pr_stage = ST_FAR_IN;
                    end
                    ST_FAR_IN: begin
                        pr_coil  = COIL_OUT;
                        pr_stage = ST_FAR_END;
                    end
                    ST_FAR_END: begin
                        pr_coil  = COIL_BRAKE;
                        pr_stage = ST_IDLE;
                        done     = 1'b1;
                        far_ok   = 1'b1;
                    end
                    default: begin
                        pr_coil  = COIL_BRAKE;
                        pr_stage = ST_IDLE;
                        done     = 1'b1;
                    end
                endcase
            end
        end
        r.coil_mode   = pr_coil;
        r.busy_res    = (pr_stage != ST_IDLE);
        r.done_res    = done;
        r.reached_far = far_ok;
        return r;
    endfunction

    // bias the sensors towards meeting, or missing, the wait in progress
    function automatic logic [3:0] pick_sensors(logic right, stage_t st);
        logic [3:0]  s;
        logic        sat;
        int unsigned r;
        int unsigned ne, fe, ni, fi;
        s  = 4'($urandom);
        r  = $urandom_range(0, 99);
        ne = right ? 3 : 0;
        fe = right ? 0 : 3;
        ni = right ? 2 : 1;
        fi = right ? 1 : 2;
        if (r >= 85)
            return s;
        sat = (r < 55);
        case (st)
            ST_ENDS: begin
                if (!sat) begin
                    s[ne] = 1'b0;
                    s[fe] = 1'b0;
                end else if ($urandom_range(0, 3) != 0) begin
                    s[ne] = 1'b1;
                end else begin
                    s[ne] = 1'b0;
                    s[fe] = 1'b1;
                end
            end
            ST_IN_SET:   s[ni] = sat;
            ST_IN_CLEAR: s[ni] = !sat;
            ST_FAR_IN:   s[fi] = sat;
            ST_FAR_END, ST_ONLY_FAR: s[fe] = sat;
            default: ;
        endcase
        return s;
    endfunction

    task automatic send_word(opcode_t op, logic dir, logic [3:0] sens);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tuser  = op;
        s_tdata  = {3'b000, sens, dir};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_words.push_back(shuttle_predict(op, dir, sens));
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic set_budget(logic [TICKS_W-1:0] ticks);
        drain_results();
        cfg_wdata = ticks;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we    = 1'b0;
        pr_budget = ticks;
    endtask

    task automatic test_idle_ticks();
        send_word(OP_TICK, 1'b0, 4'b0000);
        send_word(OP_TICK, 1'b1, 4'b1111);
    endtask

    task automatic test_full_pass();
        send_word(OP_START, 1'b0, 4'b0001);
        send_word(OP_TICK, 1'b0, 4'b0010);
        send_word(OP_TICK, 1'b0, 4'b0000);
        send_word(OP_TICK, 1'b0, 4'b0100);
        send_word(OP_TICK, 1'b0, 4'b1000);
        send_word(OP_START, 1'b1, 4'b1000);
        send_word(OP_TICK, 1'b1, 4'b0100);
        send_word(OP_TICK, 1'b1, 4'b0000);
        send_word(OP_TICK, 1'b1, 4'b0010);
        send_word(OP_TICK, 1'b1, 4'b0001);
    endtask

    task automatic test_far_end_only();
        send_word(OP_START, 1'b0, 4'b1000);
        send_word(OP_START, 1'b1, 4'b0000);
        send_word(OP_TICK, 1'b0, 4'b0001);
    endtask

    task automatic test_start_while_busy();
        send_word(OP_START, 1'b0, 4'b0000);
        send_word(OP_START, 1'b1, 4'b0001);
        send_word(OP_TICK, 1'b0, 4'b1111);
        send_word(OP_TICK, 1'b0, 4'b1101);
    endtask

    task automatic test_zero_budget();
        set_budget('0);
        send_word(OP_START, 1'b0, 4'b0001);
        send_word(OP_START, 1'b1, 4'b0000);
        send_word(OP_START, 1'b1, 4'b1111);
    endtask

    task automatic test_budget_expiry();
        set_budget(16'd2);
        send_word(OP_START, 1'b0, 4'b0000);
        send_word(OP_TICK, 1'b0, 4'b0000);
        send_word(OP_TICK, 1'b1, 4'b0000);
    endtask

    task automatic test_random_shuttles();
        logic [TICKS_W-1:0] budgets[8];
        logic               starting;
        logic               dir;
        logic [3:0]         sens;
        budgets = '{16'hffff, 16'd0, 16'd1, 16'd4,
                    16'($urandom_range(2, 30)), 16'd500, 16'($urandom), 16'd8};
        for (int p = 0; p < 8; p++) begin
            gaps_on  = (p != 3) && (p != 7);
            stall_on = (p != 4) && (p != 7);
            set_budget(budgets[p]);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (p == 2 && n == PHASE_WORDS / 2)
                    drain_results();
                dir = 1'($urandom);
                if (pr_stage == ST_IDLE) begin
                    starting = ($urandom_range(0, 9) < 7);
                    sens = starting ? pick_sensors(dir, ST_ENDS)
                                    : pick_sensors(dir, ST_IDLE);
                end else begin
                    starting = ($urandom_range(0, 9) == 0);
                    sens = pick_sensors(pr_right, pr_stage);
                end
                send_word(starting ? OP_START : OP_TICK, dir, sens);
            end
        end
    endtask

    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (stall_on && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                want_word = expected_words.pop_front();
                got_word  = css_result_t'(m_tdata[4:0]);
                if (got_word.coil_mode !== want_word.coil_mode) begin
                    $error("coil_mode expected %0d actual %0d",
                           want_word.coil_mode, got_word.coil_mode);
                    errors++;
                end
                if (got_word.busy_res !== want_word.busy_res) begin
                    $error("busy_res expected %0d actual %0d",
                           want_word.busy_res, got_word.busy_res);
                    errors++;
                end
                if (got_word.done_res !== want_word.done_res) begin
                    $error("done_res expected %0d actual %0d",
                           want_word.done_res, got_word.done_res);
                    errors++;
                end
                if (got_word.reached_far !== want_word.reached_far) begin
                    $error("reached_far expected %0d actual %0d",
                           want_word.reached_far, got_word.reached_far);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL coil_shuttle_sequencer_unit");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        pr_stage  = ST_IDLE;
        pr_coil   = COIL_BRAKE;
        pr_right  = 1'b0;
        pr_ticks  = '0;
        pr_budget = BUDGET_RESET;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_idle_ticks();
        test_full_pass();
        test_far_end_only();
        test_start_while_busy();
        test_zero_budget();
        test_budget_expiry();
        test_random_shuttles();
        drain_results();
        repeat (4) @(negedge aclk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("PASS coil_shuttle_sequencer_unit");
        end else begin
            $display("FAIL coil_shuttle_sequencer_unit");
        end
        $finish;
    end

endmodule
